### src/sliding_median_wind_speed_assert.svh
// Assertion macros for the sliding-window wind-speed median filter.
// Included by the top level; depends on nothing else.
`ifndef SLIDING_MEDIAN_WIND_SPEED_ASSERT_SVH
`define SLIDING_MEDIAN_WIND_SPEED_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMWS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMWS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/smws_pkg.sv
// Shared types and constants for the sliding-window wind-speed median filter.
// No dependencies; imported by the converter, the sorting cell and the top level.
package smws_pkg;

    localparam int SPEED_W = 16;
    localparam int KMH_W   = 18;
    // Ages count up to the largest supported window less one.
    localparam int AGE_W   = 4;

    // x*36+5 fits in 22 bits; division by ten is a multiply by ceil(2^25/10).
    localparam int             SCALED_W  = 22;
    localparam int             DIV_SHIFT = 25;
    localparam int             PROD_W    = 2 * SCALED_W;
    localparam logic [SCALED_W-1:0] DIV_MUL   = 22'd3355444;
    localparam logic [SCALED_W-1:0] ROUND_ADD = 22'd5;

    typedef struct packed {
        logic             present;
        logic [KMH_W-1:0] value;
        logic [AGE_W-1:0] age;
        logic             del;     // the oldest entry sits at or below this cell
    } cell_link_t;

endpackage

### src/smws_conv.sv
// Conversion of hundredths of m/s to hundredths of km/h, rounded to nearest.
// Depends on smws_pkg.
module smws_conv
    import smws_pkg::*;
(
    input  logic [SPEED_W-1:0] speed_ms_centi,
    output logic [KMH_W-1:0]   kmh_centi
);

    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   product;

    // x*36 as x*32 + x*4, then the rounding offset.
    assign scaled  = {1'b0, speed_ms_centi, 5'b0} + {4'b0, speed_ms_centi, 2'b0} + ROUND_ADD;
    assign product = {{SCALED_W{1'b0}}, scaled} * {{SCALED_W{1'b0}}, DIV_MUL};
    assign kmh_centi = product[DIV_SHIFT +: KMH_W];

endmodule

### src/smws_cell.sv
// One cell of the sorted window: holds a value and its age, and on each update
// drops the oldest entry and inserts the new one using only its neighbours.
// Depends on smws_pkg.
module smws_cell
    import smws_pkg::*;
#(
    parameter logic [AGE_W-1:0] INIT_AGE = '0,
    parameter logic [AGE_W-1:0] LAST_AGE = '1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             update,
    input  logic [KMH_W-1:0] new_value,
    input  cell_link_t       lo,
    input  cell_link_t       hi,
    output cell_link_t       me
);

    logic [KMH_W-1:0] value_reg, value_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             del_here;
    logic             cur_valid;
    logic [KMH_W-1:0] cur_value;
    logic [AGE_W-1:0] cur_age;
    logic [KMH_W-1:0] prev_value;
    logic [AGE_W-1:0] prev_age;
    logic             cur_le;
    logic             prev_le;

    assign del_here = lo.del | (age_reg == LAST_AGE);

    assign me.present = 1'b1;
    assign me.value   = value_reg;
    assign me.age     = age_reg;
    assign me.del     = del_here;

    // Window with the oldest entry taken out: this position and the one below.
    always_comb begin
        if (del_here) begin
            cur_valid = hi.present;
            cur_value = hi.value;
            cur_age   = hi.age;
        end else begin
            cur_valid = 1'b1;
            cur_value = value_reg;
            cur_age   = age_reg;
        end
        if (lo.del) begin
            prev_value = value_reg;
            prev_age   = age_reg;
        end else begin
            prev_value = lo.value;
            prev_age   = lo.age;
        end
        cur_le  = cur_valid && (cur_value <= new_value);
        prev_le = lo.present && (prev_value <= new_value);

        if (cur_le) begin
            value_next = cur_value;
            age_next   = cur_age + 1'b1;
        end else if (!lo.present || prev_le) begin
            value_next = new_value;
            age_next   = '0;
        end else begin
            value_next = prev_value;
            age_next   = prev_age + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            age_reg   <= INIT_AGE;
        end else if (update) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

### src/sliding_median_wind_speed.sv
// Sliding-window median of wind speed. Each transaction on the slave side
// carries one sample in hundredths of m/s; each master transaction returns
// that sample in hundredths of km/h and the median of the last WINDOW samples
// (floor of the middle-pair mean for an even window). Reset fills the window
// with zeros, which count as samples until overwritten. One sample is taken
// per clock cycle while no result waits unread: the converted sample is
// registered on acceptance, then the row of sorting cells updates from it,
// and then the median is registered together with that converted sample.
// The whole pipeline stalls only while a result waits unread.
// Depends on smws_pkg, smws_conv, smws_cell and the assertion macro header.
`include "sliding_median_wind_speed_assert.svh"

module sliding_median_wind_speed
    import smws_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] speed_ms_centi
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [17:0] latest_kmh_centi, [35:18] median_kmh_centi
);

    localparam int MID = WINDOW / 2;

    logic             advance;
    logic [KMH_W-1:0] kmh_conv;

    logic             stage1_valid_reg;
    logic [KMH_W-1:0] stage1_kmh_reg;
    logic             stage2_valid_reg;
    logic [KMH_W-1:0] stage2_kmh_reg;
    logic             out_valid_reg;
    logic [KMH_W-1:0] out_latest_reg;
    logic [KMH_W-1:0] out_median_reg;
    logic [KMH_W-1:0] median_next;

    cell_link_t       link [WINDOW];
    logic [WINDOW-1:0] oldest_vec;
    logic [WINDOW-2:0] order_ok;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_median_reg, out_latest_reg};

    smws_conv u_conv (
        .speed_ms_centi (s_tdata[SPEED_W-1:0]),
        .kmh_centi      (kmh_conv)
    );

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            cell_link_t lo_link;
            cell_link_t hi_link;
            if (gi == 0) begin : g_bottom
                assign lo_link = '0;
            end else begin : g_lo
                assign lo_link = link[gi-1];
            end
            if (gi == WINDOW - 1) begin : g_top
                assign hi_link = '0;
            end else begin : g_hi
                assign hi_link = link[gi+1];
            end

            smws_cell #(
                .INIT_AGE (AGE_W'(gi)),
                .LAST_AGE (AGE_W'(WINDOW - 1))
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .update    (advance && stage1_valid_reg),
                .new_value (stage1_kmh_reg),
                .lo        (lo_link),
                .hi        (hi_link),
                .me        (link[gi])
            );

            assign oldest_vec[gi] = (link[gi].age == AGE_W'(WINDOW - 1));
            if (gi < WINDOW - 1) begin : g_order
                assign order_ok[gi] = (link[gi].value <= link[gi+1].value);
            end
        end

        if ((WINDOW % 2) == 0) begin : g_even
            logic [KMH_W:0] pair_sum;
            assign pair_sum    = {1'b0, link[MID-1].value} + {1'b0, link[MID].value};
            assign median_next = pair_sum[KMH_W:1];
        end else begin : g_odd
            assign median_next = link[MID].value;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else if (advance) begin
            stage1_valid_reg <= s_tvalid;
            stage2_valid_reg <= stage1_valid_reg;
            out_valid_reg    <= stage2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            stage1_kmh_reg <= kmh_conv;
            stage2_kmh_reg <= stage1_kmh_reg;
            out_latest_reg <= stage2_kmh_reg;
            out_median_reg <= median_next;
        end
    end

    // Exactly one cell holds the oldest sample, and the row stays in ascending order.
    `SMWS_ASSERT_NOW(a_one_oldest, aclk, aresetn, 1'b1, $onehot(oldest_vec), "oldest entry not unique")
    `SMWS_ASSERT_NEXT(a_row_sorted, aclk, aresetn, 1'b1, (&order_ok), "cell row out of order")

endmodule
